### rtl/vasq_pkg.sv
// ----------------------------------------------------------------------------
// vasq_pkg
// Shared constants, types and the boundary tangent table of the vector angle
// sector quantizer.
// ----------------------------------------------------------------------------
package vasq_pkg;

  localparam int unsigned SECTOR_COUNT = 128;
  localparam int unsigned OCT_SECTORS  = SECTOR_COUNT / 8;
  localparam int unsigned SECTOR_W     = $clog2(SECTOR_COUNT);
  localparam int unsigned WITHIN_W     = $clog2(2 * OCT_SECTORS);
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned DIFF_W       = COORD_W + 1;
  localparam int unsigned TAN_W        = 32;
  localparam int unsigned PROD_W       = TAN_W + COORD_W;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [63:0] PI_OVER_4_Q64 = 64'hC90F_DAA2_2168_C235;

  typedef logic [63:0] u64_t;
  typedef logic [OCT_SECTORS-1:1][TAN_W-1:0] tan_tab_t;

  // folded vector: quadrant, octant half and the two magnitudes
  typedef struct packed {
    logic               zero;
    logic [1:0]         quad;
    logic               lower;
    logic [COORD_W-1:0] minor;
    logic [COORD_W-1:0] major;
  } fold_t;

  // upper 64 bits of a 64 x 64 product
  function automatic u64_t mul_hi(input u64_t a, input u64_t b);
    logic [127:0] p;
    begin
      p = {64'd0, a} * {64'd0, b};
      return p[127:64];
    end
  endfunction

  // restoring shift-subtract division, evaluated while building the table
  function automatic u64_t udiv64(input u64_t num, input u64_t den);
    logic [64:0] rem;
    u64_t        quo;
    begin
      rem = '0;
      quo = '0;
      for (int k = 63; k >= 0; k--) begin
        rem = {rem[63:0], num[k]};
        if (rem >= {1'b0, den}) begin
          rem    = rem - {1'b0, den};
          quo[k] = 1'b1;
        end
      end
      return quo;
    end
  endfunction

  // tan(i * (pi/4) / OCT_SECTORS) in unsigned Q0.32, via Taylor series in Q0.64
  function automatic logic [TAN_W-1:0] boundary_tan(input u64_t i);
    u64_t a;
    u64_t a2;
    u64_t s;
    u64_t t;
    u64_t c;
    u64_t q;
    u64_t r;
    u64_t n;
    u64_t qr;
    logic carry;
    begin
      a = (PI_OVER_4_Q64 / OCT_SECTORS) * i
          + (((PI_OVER_4_Q64 % OCT_SECTORS) * i) / OCT_SECTORS);
      a2 = mul_hi(a, a);
      s  = a;
      t  = a;
      n  = 64'd1;
      while (n < 64'd24 && t != 64'd0) begin
        t = udiv64(mul_hi(t, a2), (2 * n) * (2 * n + 1));
        if (n[0]) s = s - t;
        else      s = s + t;
        n = n + 64'd1;
      end
      t = a2 >> 1;
      c = 64'd0 - t;
      n = 64'd2;
      while (n < 64'd24 && t != 64'd0) begin
        t = udiv64(mul_hi(t, a2), (2 * n - 1) * (2 * n));
        if (n[0]) c = c - t;
        else      c = c + t;
        n = n + 64'd1;
      end
      r = s;
      q = '0;
      for (int k = 0; k < 33; k++) begin
        carry = r[63];
        r     = r << 1;
        q     = q << 1;
        if (carry || r >= c) begin
          r    = r - c;
          q[0] = 1'b1;
        end
      end
      qr = (q + 64'd1) >> 1;
      return qr[TAN_W-1:0];
    end
  endfunction

  function automatic tan_tab_t build_tan_tab();
    tan_tab_t tab;
    begin
      for (int unsigned i = 1; i < OCT_SECTORS; i++) begin
        tab[i] = boundary_tan(u64_t'(i));
      end
      return tab;
    end
  endfunction

  localparam tan_tab_t TAN_TAB = build_tan_tab();

endpackage

### rtl/vasq_fold.sv
// ----------------------------------------------------------------------------
// vasq_fold
// Forms the difference vector and folds it into a quadrant and an octant
// half, giving the minor and major magnitudes.
// ----------------------------------------------------------------------------
module vasq_fold (
  input  logic [vasq_pkg::COORD_W-1:0] first_x,
  input  logic [vasq_pkg::COORD_W-1:0] first_y,
  input  logic [vasq_pkg::COORD_W-1:0] second_x,
  input  logic [vasq_pkg::COORD_W-1:0] second_y,
  output vasq_pkg::fold_t              fold
);

  logic signed [vasq_pkg::DIFF_W-1:0] dx;
  logic signed [vasq_pkg::DIFF_W-1:0] dy;
  logic signed [vasq_pkg::DIFF_W-1:0] ndx;
  logic signed [vasq_pkg::DIFF_W-1:0] ndy;
  logic        [vasq_pkg::COORD_W-1:0] u;
  logic        [vasq_pkg::COORD_W-1:0] v;
  logic                                dx_pos;
  logic                                dx_neg;
  logic                                dy_pos;
  logic                                dy_neg;

  assign dx  = $signed({first_x[vasq_pkg::COORD_W-1], first_x})
             - $signed({second_x[vasq_pkg::COORD_W-1], second_x});
  assign dy  = $signed({first_y[vasq_pkg::COORD_W-1], first_y})
             - $signed({second_y[vasq_pkg::COORD_W-1], second_y});
  assign ndx = -dx;
  assign ndy = -dy;

  assign dx_neg = dx[vasq_pkg::DIFF_W-1];
  assign dy_neg = dy[vasq_pkg::DIFF_W-1];
  assign dx_pos = !dx_neg && (dx != '0);
  assign dy_pos = !dy_neg && (dy != '0);

  // axes and diagonals belong to the sector that starts there
  always_comb begin
    if (dx_pos && !dy_neg) begin
      fold.quad = vasq_pkg::QUAD_0;
      u = dx[vasq_pkg::COORD_W-1:0];
      v = dy[vasq_pkg::COORD_W-1:0];
    end else if (!dx_pos && dy_pos) begin
      fold.quad = vasq_pkg::QUAD_1;
      u = dy[vasq_pkg::COORD_W-1:0];
      v = ndx[vasq_pkg::COORD_W-1:0];
    end else if (dx_neg && !dy_pos) begin
      fold.quad = vasq_pkg::QUAD_2;
      u = ndx[vasq_pkg::COORD_W-1:0];
      v = ndy[vasq_pkg::COORD_W-1:0];
    end else begin
      fold.quad = vasq_pkg::QUAD_3;
      u = ndy[vasq_pkg::COORD_W-1:0];
      v = dx[vasq_pkg::COORD_W-1:0];
    end
    fold.zero  = (dx == '0) && (dy == '0);
    fold.lower = (v < u);
    fold.minor = fold.lower ? v : u;
    fold.major = fold.lower ? u : v;
  end

endmodule

### rtl/vasq_sector.sv
// ----------------------------------------------------------------------------
// vasq_sector
// Compares the minor/major ratio against the boundary tangents of one octant
// and forms the sector number.
// ----------------------------------------------------------------------------
module vasq_sector (
  input  vasq_pkg::fold_t                fold,
  output logic [vasq_pkg::SECTOR_W-1:0]  sector
);

  logic [vasq_pkg::OCT_SECTORS-1:1]  hits;
  logic [vasq_pkg::WITHIN_W-1:0]     count;
  logic [vasq_pkg::WITHIN_W-1:0]     oct_pos;
  logic [vasq_pkg::PROD_W-1:0]       minor_sh;

  assign minor_sh = {fold.minor, {vasq_pkg::TAN_W{1'b0}}};

  // one constant product per boundary, all independent
  always_comb begin
    for (int unsigned i = 1; i < vasq_pkg::OCT_SECTORS; i++) begin
      if (fold.lower) begin
        hits[i] = minor_sh >= ({{vasq_pkg::COORD_W{1'b0}}, vasq_pkg::TAN_TAB[i]}
                               * {{vasq_pkg::TAN_W{1'b0}}, fold.major});
      end else begin
        hits[i] = minor_sh <= ({{vasq_pkg::COORD_W{1'b0}}, vasq_pkg::TAN_TAB[i]}
                               * {{vasq_pkg::TAN_W{1'b0}}, fold.major});
      end
    end
  end

  assign count  = vasq_pkg::WITHIN_W'($countones(hits));
  // upper half of the octant starts at the diagonal
  assign oct_pos = fold.lower ? count
                 : vasq_pkg::WITHIN_W'(vasq_pkg::OCT_SECTORS) + count;

  assign sector = fold.zero ? '0
                : vasq_pkg::SECTOR_W'({fold.quad, oct_pos});

endmodule

### rtl/vector_angle_sector_quantizer.sv
// ----------------------------------------------------------------------------
// vector_angle_sector_quantizer
// Direction of the vector from the second point to the first, as one of 128
// equal sectors counted from +x toward +y.
//
// channel   dir  data
// s_axis    in   first_x, first_y, second_x, second_y (16 bit signed each)
// m_axis    out  sector (7 bit)
//
// one request per cycle while m_axis does not stall; an accepted request passes
// through the input register, then through fold and tangent compares into the
// result register, which drives m_axis
// rst clears both valid flags; payload registers are not reset
// a stall on m_axis holds the result register and backs up into the input
// register; s_axis_tready stays high while either stage can move on
// ----------------------------------------------------------------------------
module vector_angle_sector_quantizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // first_x, first_y, second_x, second_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // sector, zero
);

  localparam int unsigned CW = vasq_pkg::COORD_W;

  logic                            in_valid;
  logic [4*CW-1:0]                 in_data;
  logic                            out_valid;
  logic [vasq_pkg::SECTOR_W-1:0]   out_sector;
  logic                            out_free;
  logic                            in_free;
  vasq_pkg::fold_t                 fold;
  logic [vasq_pkg::SECTOR_W-1:0]   sector_next;

  assign out_free      = !out_valid || m_axis_tready;
  assign in_free       = !in_valid || out_free;
  assign s_axis_tready = in_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_free) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && s_axis_tvalid) begin
      in_data <= s_axis_tdata;
    end
  end

  vasq_fold u_fold (
    .first_x  (in_data[CW-1:0]),
    .first_y  (in_data[2*CW-1:CW]),
    .second_x (in_data[3*CW-1:2*CW]),
    .second_y (in_data[4*CW-1:3*CW]),
    .fold     (fold)
  );

  vasq_sector u_sector (
    .fold   (fold),
    .sector (sector_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid) begin
      out_sector <= sector_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(8 - vasq_pkg::SECTOR_W){1'b0}}, out_sector};

endmodule

### sim/vasq_checker.sv
// ----------------------------------------------------------------------------
// vasq_checker
// Watches both streams of the vector angle sector quantizer, predicts the
// sector of every accepted request from its own boundary tangent table and
// compares each returned sector, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vasq_checker
  import vasq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // first_x, first_y, second_x, second_y
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // sector, zero
  output int          mismatches,
  output int          sectors_due
);

  logic [TAN_W-1:0]    bound_tan [1:OCT_SECTORS-1];
  logic [SECTOR_W-1:0] sector_due_q [$];
  int                  fail_total = 0;
  int                  due_count  = 0;

  assign mismatches  = fail_total;
  assign sectors_due = due_count;

  // high half of a 64 x 64 product, built from 32-bit pieces
  function automatic longint unsigned hi_product(input longint unsigned a,
                                                 input longint unsigned b);
    longint unsigned al, ah, bl, bh, ll, lh, hl, hh, mid;
    al  = {32'd0, a[31:0]};
    ah  = {32'd0, a[63:32]};
    bl  = {32'd0, b[31:0]};
    bh  = {32'd0, b[63:32]};
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
    return hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
  endfunction

  // tan(idx * (pi/4) / OCT_SECTORS) as Q0.32, series in Q0.64
  function automatic logic [TAN_W-1:0] sector_bound_tan(input int unsigned idx);
    longint unsigned p, a, a2, s, t, c, q, r, n;
    logic            carry;
    p  = OCT_SECTORS;
    a  = (PI_OVER_4_Q64 / p) * idx + ((PI_OVER_4_Q64 % p) * idx) / p;
    a2 = hi_product(a, a);
    s  = a;
    t  = a;
    for (n = 1; n < 24 && t != 0; n++) begin
      t = hi_product(t, a2) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - t;
      else            s = s + t;
    end
    // cosine starts at 1.0 - a^2/2, wrapping through 2^64
    t = a2 >> 1;
    c = 64'd0 - t;
    for (n = 2; n < 24 && t != 0; n++) begin
      t = hi_product(t, a2) / ((2 * n - 1) * (2 * n));
      if (n % 2 == 1) c = c - t;
      else            c = c + t;
    end
    r = s;
    q = 0;
    for (int k = 0; k < 33; k++) begin
      carry = r[63];
      r     = r << 1;
      q     = q << 1;
      if (carry || r >= c) begin
        r = r - c;
        q = q | 64'd1;
      end
    end
    q = (q + 1) >> 1;
    return q[TAN_W-1:0];
  endfunction

  function automatic logic [SECTOR_W-1:0] sector_of(input logic [63:0] word);
    logic signed [COORD_W-1:0] fx, fy, sx, sy;
    int                        dx, dy;
    longint unsigned           u, v, oct_pos, sector;
    logic [1:0]                quad;
    fx = word[15:0];
    fy = word[31:16];
    sx = word[47:32];
    sy = word[63:48];
    dx = fx - sx;
    dy = fy - sy;
    if (dx == 0 && dy == 0) return '0;
    if (dx > 0 && dy >= 0) begin
      quad = QUAD_0; u = dx;  v = dy;
    end else if (dx <= 0 && dy > 0) begin
      quad = QUAD_1; u = dy;  v = -dx;
    end else if (dx < 0 && dy <= 0) begin
      quad = QUAD_2; u = -dx; v = -dy;
    end else begin
      quad = QUAD_3; u = -dy; v = dx;
    end
    oct_pos = 0;
    if (v < u) begin
      for (int i = 1; i < OCT_SECTORS; i++)
        if ((v << 32) >= longint'(bound_tan[i]) * u) oct_pos++;
    end else begin
      oct_pos = OCT_SECTORS;
      for (int i = 1; i < OCT_SECTORS; i++)
        if ((u << 32) <= longint'(bound_tan[i]) * v) oct_pos++;
    end
    sector = quad * (2 * OCT_SECTORS) + oct_pos;
    return sector[SECTOR_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_total++;
  endtask

  initial begin
    for (int i = 1; i < OCT_SECTORS; i++) bound_tan[i] = sector_bound_tan(i);
  end

  always @(posedge clk) begin
    logic [SECTOR_W-1:0] want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sector_due_q.push_back(sector_of(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (sector_due_q.size() == 0) begin
          report_mismatch("sector with no request outstanding", m_axis_tdata, -1);
        end else begin
          want = sector_due_q.pop_front();
          if (m_axis_tdata[SECTOR_W-1:0] !== want)
            report_mismatch("sector", m_axis_tdata[SECTOR_W-1:0], want);
          if (m_axis_tdata[7] !== 1'b0)
            report_mismatch("pad bit", m_axis_tdata[7], 0);
        end
      end
      due_count <= sector_due_q.size();
    end
  end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives coordinate pairs into the vector angle sector quantizer: a directed
// set of axes, diagonals, zero vectors and range extremes, then random phases
// mixing free coordinates with vectors placed right beside sector bounds,
// under varying source gaps and sink stalls. Checking sits in vasq_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import vasq_pkg::*;

  localparam real PI_VAL = 3.14159265358979;
  localparam int  RANDOM_PER_PHASE = 345;
  localparam int  MAX_DIFF = 65535;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        s_valid = 1'b0;
  logic [63:0] s_data  = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [7:0]  m_axis_tdata;
  int          mismatches;
  int          sectors_due;
  int          send_gap_max   = 12;
  int          recv_stall_max = 12;
  int          gap_plan   [5] = '{12, 0, 12, 0, 3};
  int          stall_plan [5] = '{12, 0, 0, 12, 3};
  int          coord_corner [8] = '{-32768, -32767, -1, 0, 1, 2, 32766, 32767};

  always #5 clk = ~clk;

  vector_angle_sector_quantizer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  vasq_checker sector_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .sectors_due   (sectors_due)
  );

  function automatic logic [63:0] pack(input int fx, input int fy, input int sx, input int sy);
    return {16'(sy), 16'(sx), 16'(fy), 16'(fx)};
  endfunction

  function automatic int clamp_diff(input int d);
    return (d > MAX_DIFF) ? MAX_DIFF : (d < -MAX_DIFF) ? -MAX_DIFF : d;
  endfunction

  // random second point such that first = second + (dx, dy) stays in range
  function automatic logic [63:0] endpoints_for(input int dx, input int dy);
    int lo_x, hi_x, lo_y, hi_y, sx, sy;
    lo_x = (dx > 0) ? -32768 : -32768 - dx;
    hi_x = (dx > 0) ? 32767 - dx : 32767;
    lo_y = (dy > 0) ? -32768 : -32768 - dy;
    hi_y = (dy > 0) ? 32767 - dy : 32767;
    sx = lo_x + int'($urandom_range(hi_x - lo_x));
    sy = lo_y + int'($urandom_range(hi_y - lo_y));
    return pack(sx + dx, sy + dy, sx, sy);
  endfunction

  // folded magnitudes back into a quadrant
  function automatic logic [63:0] unfold(input logic [1:0] quad, input int u, input int v);
    case (quad)
      QUAD_0:  return endpoints_for(u, v);
      QUAD_1:  return endpoints_for(-v, u);
      QUAD_2:  return endpoints_for(-u, -v);
      default: return endpoints_for(v, -u);
    endcase
  endfunction

  // minor/major ratio within a couple of pixels of a bound tangent
  function automatic logic [63:0] near_bound();
    logic [1:0] quad;
    int         idx, major, minor;
    real        slope;
    quad  = 2'($urandom_range(3));
    idx   = $urandom_range(OCT_SECTORS - 1, 1);
    major = $urandom_range(MAX_DIFF, 1);
    slope = $tan(idx * PI_VAL / (4.0 * OCT_SECTORS));
    minor = $rtoi(major * slope) + int'($urandom_range(4)) - 2;
    minor = (minor < 0) ? 0 : clamp_diff(minor);
    if ($urandom_range(1)) return unfold(quad, major, minor);
    else                   return unfold(quad, minor, major);
  endfunction

  function automatic logic [63:0] random_vector();
    int pick, m, jitter, dx, dy;
    pick = $urandom_range(99);
    if (pick < 35) return {$urandom, $urandom};
    if (pick < 60) return near_bound();
    if (pick < 75) return endpoints_for(int'($urandom_range(6)) - 3, int'($urandom_range(6)) - 3);
    if (pick < 85)
      return pack(coord_corner[$urandom_range(7)], coord_corner[$urandom_range(7)],
                  coord_corner[$urandom_range(7)], coord_corner[$urandom_range(7)]);
    // axes and diagonals, sometimes nudged off by one
    m      = $urandom_range(MAX_DIFF, 1);
    jitter = int'($urandom_range(2)) - 1;
    case ($urandom_range(7))
      0:       begin dx = m;  dy = 0;  end
      1:       begin dx = m;  dy = m;  end
      2:       begin dx = 0;  dy = m;  end
      3:       begin dx = -m; dy = m;  end
      4:       begin dx = -m; dy = 0;  end
      5:       begin dx = -m; dy = -m; end
      6:       begin dx = 0;  dy = -m; end
      default: begin dx = m;  dy = -m; end
    endcase
    if ($urandom_range(1)) dx = clamp_diff(dx + jitter);
    else                   dy = clamp_diff(dy + jitter);
    return endpoints_for(dx, dy);
  endfunction

  task automatic send_vector(input logic [63:0] word);
    int gap;
    gap = $urandom_range(send_gap_max);
    repeat (gap) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= word;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // hold off until every outstanding request has its sector back
  task automatic drain_all();
    s_valid <= 1'b0;
    @(posedge clk);
    while (sectors_due != 0) @(posedge clk);
  endtask

  // result sink: fresh stall before each sector
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(recv_stall_max);
      repeat (stall) begin
        m_ready <= 1'b0;
        @(posedge clk);
      end
      m_ready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  initial begin
    #5000000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // zero vectors
    send_vector(pack(0, 0, 0, 0));
    send_vector(pack(-32768, -32768, -32768, -32768));
    send_vector(pack(32767, 32767, 32767, 32767));
    // unit axes and diagonals
    send_vector(pack(1, 0, 0, 0));
    send_vector(pack(0, 1, 0, 0));
    send_vector(pack(-1, 0, 0, 0));
    send_vector(pack(0, -1, 0, 0));
    send_vector(pack(1, 1, 0, 0));
    send_vector(pack(-1, 1, 0, 0));
    send_vector(pack(-1, -1, 0, 0));
    send_vector(pack(1, -1, 0, 0));
    // full-range differences
    send_vector(pack(32767, 0, -32768, 0));
    send_vector(pack(-32768, 0, 32767, 0));
    send_vector(pack(0, 32767, 0, -32768));
    send_vector(pack(0, -32768, 0, 32767));
    send_vector(pack(32767, 32767, -32768, -32768));
    send_vector(pack(-32768, 32767, 32767, -32768));
    send_vector(pack(32767, -32768, -32768, 32767));
    send_vector(pack(-32768, -32768, 32767, 32767));
    // just off the axes and the diagonal
    send_vector(pack(32767, 1, -32768, 0));
    send_vector(pack(32767, -1, -32768, 0));
    send_vector(pack(1, 32767, 0, -32768));
    send_vector(pack(-1, -32768, 0, 32767));
    send_vector(pack(32767, 32766, -32768, -32768));
    drain_all();

    for (int phase = 0; phase < 5; phase++) begin
      send_gap_max   = gap_plan[phase];
      recv_stall_max = stall_plan[phase];
      repeat (RANDOM_PER_PHASE) send_vector(random_vector());
      drain_all();
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0 && sectors_due == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
